FILE: rtl/md5_hash_core_defines.svh
// Assertion macros for the MD5 hash core.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MD5_HASH_CORE_DEFINES_SVH
`define MD5_HASH_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MD5_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("md5_hash_core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("md5_hash_core: next-cycle check failed");

`endif

FILE: rtl/md5_pkg.sv
// Shared types, constants and round tables for the MD5 hash core.
// No dependencies.
package md5_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned BufAw    = $clog2(BufDepth);
  localparam int unsigned RndW     = 6;

  localparam logic [BufAw-1:0] BlockLast = BufAw'(BufDepth - 1);

  // Initial chaining value, index 0 = A.
  localparam logic [3:0][WordW-1:0] InitChain = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef struct packed {
    logic [31:0] msg_word;
    logic        msg_start;
    logic        msg_end;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } out_t;

  // Sine-derived additive constant of each round.
  function automatic logic [31:0] sine_k(input logic [RndW-1:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount: row by quarter, column by round mod 4.
  function automatic logic [4:0] rot_amt(input logic [RndW-1:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'hA: s = 5'd16;  4'hB: s = 5'd23;
      4'hC: s = 5'd6;   4'hD: s = 5'd10;  4'hE: s = 5'd15;  4'hF: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Buffer word used by a round; only r mod 16 matters for the products.
  function automatic logic [BufAw-1:0] msg_index(input logic [RndW-1:0] r);
    logic [BufAw-1:0] lo;
    logic [BufAw-1:0] g;
    lo = r[BufAw-1:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = BufAw'((lo << 2) + lo + 4'd1);
      2'd2:    g = BufAw'((lo << 1) + lo + 4'd5);
      2'd3:    g = BufAw'((lo << 3) - lo);
      default: g = lo;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/md5_hash_core.sv
// MD5 hash core top level: word intake, block RAM, round sequencer, digest out.
// Depends on md5_pkg, md5_ram, md5_round and md5_hash_core_defines.svh.
//
// Input channel (in_valid_i / in_stall_o / in_i) takes one padded, little-endian
// message word per accepted word; msg_start restarts at block word zero with the
// initial chaining value, msg_end on block word fifteen closes the message.
// Words go into a 16-entry block RAM. Block words 0..14 are only written there.
// Word fifteen starts a compression: 64 rounds, one round per cycle, each with its
// RAM read issued in the cycle before, then the add into the chaining value.
// in_stall_o is high through the rounds and the add, so no word is taken while a
// block compresses; the compression loop sets the rate.
// If the message ended, the four digest words (A, B, C, D, last flag on D) sit
// in a digest register and leave on out_valid_o / out_stall_i from the cycle
// after the add, one per cycle while not stalled. Input words keep flowing while
// the digest drains; only the next message end waits for the digest to empty.
// Reset loads the initial chaining value, clears counters and drops valid.
`include "md5_hash_core_defines.svh"

module md5_hash_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  md5_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output md5_pkg::out_t out_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StFold  = 2'd2;

  localparam logic [md5_pkg::RndW-1:0] RndLast = '1;

  logic [1:0] state_q, state_d;
  logic [md5_pkg::BufAw-1:0] wcnt_q, wcnt_d;
  logic [md5_pkg::RndW-1:0]  rnd_q, rnd_d;
  logic end_q, end_d;
  logic [3:0][31:0] chain_q, chain_d;
  logic [3:0][31:0] wk_q, wk_d;
  logic [3:0][31:0] dig_q, dig_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] out_idx_q, out_idx_d;

  logic in_accept;
  logic [md5_pkg::BufAw-1:0] pos;
  logic blk_done;
  logic [md5_pkg::BufAw-1:0] raddr;
  logic [31:0] m_word;
  logic [31:0] new_b;
  logic fold_go;
  logic out_pop;
  logic [3:0][31:0] chain_sum;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pos        = in_i.msg_start ? '0 : wcnt_q;
  assign blk_done   = in_accept && (pos == md5_pkg::BlockLast);

  // Round 0 reads word 0 while the last word is written; later rounds prefetch.
  assign raddr = (state_q == StRound) ? md5_pkg::msg_index(rnd_q + 1'b1) : '0;

  md5_ram #(
    .Width(md5_pkg::WordW),
    .Depth(md5_pkg::BufDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (in_accept),
    .waddr_i(pos),
    .wdata_i(in_i.msg_word),
    .raddr_i(raddr),
    .rdata_o(m_word)
  );

  md5_round u_round (
    .a_i  (wk_q[0]),
    .b_i  (wk_q[1]),
    .c_i  (wk_q[2]),
    .d_i  (wk_q[3]),
    .m_i  (m_word),
    .rnd_i(rnd_q),
    .b_o  (new_b)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chain_sum[i] = chain_q[i] + wk_q[i];
    end
  end

  assign out_pop = out_valid_q && !out_stall_i;
  // a finishing message waits until the previous digest has fully left
  assign fold_go = (state_q == StFold) && (!end_q || !out_valid_q);

  always_comb begin
    state_d     = state_q;
    wcnt_d      = wcnt_q;
    rnd_d       = rnd_q;
    end_d       = end_q;
    chain_d     = chain_q;
    wk_d        = wk_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;

    if (in_accept) begin
      wcnt_d = pos + 1'b1;
      if (in_i.msg_start) begin
        chain_d = md5_pkg::InitChain;
      end
    end

    case (state_q)
      StIdle: begin
        if (blk_done) begin
          state_d = StRound;
          rnd_d   = '0;
          end_d   = in_i.msg_end;
          wk_d    = chain_q;
        end
      end
      StRound: begin
        wk_d  = {wk_q[2], wk_q[1], new_b, wk_q[3]};
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndLast) begin
          state_d = StFold;
        end
      end
      StFold: begin
        if (fold_go) begin
          chain_d = chain_sum;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (fold_go && end_q) begin
      dig_d       = chain_sum;
      out_valid_d = 1'b1;
      out_idx_d   = '0;
    end else if (out_pop) begin
      out_idx_d   = out_idx_q + 1'b1;
      out_valid_d = (out_idx_q != 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wcnt_q      <= '0;
      rnd_q       <= '0;
      end_q       <= 1'b0;
      chain_q     <= md5_pkg::InitChain;
      wk_q        <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      rnd_q       <= rnd_d;
      end_q       <= end_d;
      chain_q     <= chain_d;
      wk_q        <= wk_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_o.digest_word = dig_q[out_idx_q];
  assign out_o.word_index  = out_idx_q;
  assign out_o.digest_last = (out_idx_q == 2'd3);

  `MD5_ASSERT_NEXT(a_blk_starts_rounds, blk_done, (state_q == StRound) && (rnd_q == '0))
  `MD5_ASSERT_NEXT(a_rounds_end_fold, (state_q == StRound) && (rnd_q == RndLast),
                   state_q == StFold)
  `MD5_ASSERT_NEXT(a_digest_from_a, fold_go && end_q, out_valid_o && (out_idx_q == 2'd0))
  `MD5_ASSERT_SAME(a_no_intake_busy, (state_q == StRound) || (state_q == StFold),
                   !in_accept)

endmodule

FILE: rtl/md5_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/md5_round.sv
// One MD5 round: boolean function, constant add, rotate and add into B.
// Depends on md5_pkg for the constant and rotate tables.
module md5_round (
  input  logic [31:0]                a_i,
  input  logic [31:0]                b_i,
  input  logic [31:0]                c_i,
  input  logic [31:0]                d_i,
  input  logic [31:0]                m_i,
  input  logic [md5_pkg::RndW-1:0]   rnd_i,
  output logic [31:0]                b_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;

  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (b_i & d_i) | (c_i & ~d_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      2'd3:    f = c_i ^ (b_i | ~d_i);
      default: f = '0;
    endcase
  end

  assign sum      = a_i + f + m_i + md5_pkg::sine_k(rnd_i);
  // rotate left via doubled word
  assign rot_wide = {sum, sum} << md5_pkg::rot_amt(rnd_i);
  assign b_o      = b_i + rot_wide[63:32];

endmodule

FILE: tb/sv/md5_digest_checker.sv
// Digest checker for md5_hash_core: watches both channels and predicts digest words.
// Depends on md5_pkg for the channel word types.
`timescale 1ns / 100ps

module md5_digest_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  md5_pkg::in_t  in_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  md5_pkg::out_t out_i,
  output int            err_count_o,
  output int            pending_o
);
  import md5_pkg::*;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Four rotate amounts per quarter, indexed {quarter, round mod 4}.
  localparam int unsigned ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [3:0][31:0] MD5_IV = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  logic [3:0][31:0]  chain_val;
  logic [15:0][31:0] blk_buf;
  logic [3:0]        blk_pos;
  out_t              digest_q [$];
  out_t              exp_w;

  // One full block: 64 rounds, then the add into the chaining value.
  function automatic logic [3:0][31:0] md5_compress(input logic [3:0][31:0] cv,
                                                    input logic [15:0][31:0] blk);
    logic [31:0] a, b, c, d, f, t, sum;
    int unsigned g, s;
    a = cv[0];
    b = cv[1];
    c = cv[2];
    d = cv[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * r + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * r + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * r;
        end
      endcase
      s   = ROT_AMT[(r / 16) * 4 + r % 4];
      sum = a + f + blk[g % 16] + SINE_K[r];
      t   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
      a   = t;
    end
    return {cv[3] + d, cv[2] + c, cv[1] + b, cv[0] + a};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_val = MD5_IV;
      blk_buf   = '0;
      blk_pos   = '0;
      digest_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (in_i.msg_start) begin
          chain_val = MD5_IV;
          blk_pos   = '0;
        end
        blk_buf[blk_pos] = in_i.msg_word;
        // end flag only counts on block word fifteen
        if (blk_pos == 4'd15) begin
          chain_val = md5_compress(chain_val, blk_buf);
          if (in_i.msg_end) begin
            for (int k = 0; k < 4; k++) begin
              exp_w.digest_word = chain_val[k];
              exp_w.word_index  = 2'(k);
              exp_w.digest_last = (k == 3);
              digest_q.push_back(exp_w);
            end
          end
        end
        blk_pos = blk_pos + 4'd1;
      end

      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          err_count_o++;
          $display("%0t: digest word with none expected: expected none, actual %08h/%0d/%0b",
                   $time, out_i.digest_word, out_i.word_index, out_i.digest_last);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_i.digest_word !== exp_w.digest_word) begin
            err_count_o++;
            $display("%0t: digest_word mismatch: expected %08h, actual %08h",
                     $time, exp_w.digest_word, out_i.digest_word);
          end
          if (out_i.word_index !== exp_w.word_index) begin
            err_count_o++;
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, exp_w.word_index, out_i.word_index);
          end
          if (out_i.digest_last !== exp_w.digest_last) begin
            err_count_o++;
            $display("%0t: digest_last mismatch: expected %0b, actual %0b",
                     $time, exp_w.digest_last, out_i.digest_last);
          end
        end
      end
      pending_o = digest_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for md5_hash_core: clock, reset, message word stimulus and verdict.
// Depends on md5_pkg, md5_hash_core and md5_digest_checker.
`timescale 1ns / 100ps

module tb_top;
  import md5_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 380;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_pl = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_pl;

  int err_count;
  int pending;
  int cycle_cnt = 0;
  int items_sent = 0;
  int src_idle_pct = 38;
  int rx_stall_pct = 55;
  logic [3:0] blk_pos = '0;

  md5_hash_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_pl),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_pl)
  );

  md5_digest_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_pl),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_pl),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_item(input logic [31:0] w, input bit st, input bit fin);
    in_t pl;
    bit  taken;
    pl.msg_word  = w;
    pl.msg_start = st;
    pl.msg_end   = fin;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pl    <= pl;
    taken = 1'b0;
    // stall is stable from the falling edge to the next rising edge
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (st) blk_pos = '0;
    blk_pos = blk_pos + 4'd1;
    items_sent++;
    if (items_sent == 135) begin
      src_idle_pct = 55;
      rx_stall_pct = 38;
    end else if (items_sent == 270) begin
      src_idle_pct = 0;
      rx_stall_pct = 0;
    end
  endtask

  // Fill the rest of the current block, or a whole new one with a start flag.
  task automatic send_tail(input bit close_msg, input bit st);
    int n;
    n = st ? 16 : 16 - blk_pos;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_item(rand_word(), st && i == 0, close_msg);
      else send_item(rand_word(), st && i == 0, $urandom_range(11) == 0);
    end
  endtask

  initial begin
    int sel;
    int nblk;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start and end on word zero, a stray end mid-block, alternating extremes
    for (int i = 0; i < 16; i++) begin
      send_item(i[0] ? 32'hffff_ffff : 32'h0000_0000, i == 0,
                i == 0 || i == 7 || i == 15);
    end
    // a message cut short; the next start restarts mid-block
    for (int i = 0; i < 8; i++) begin
      send_item(32'h8000_0001 >> i, i == 0, 1'b0);
    end

    while (items_sent < RAND_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        nblk = ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
        for (int b = 0; b < nblk; b++) send_tail(b == nblk - 1, b == 0);
      end else if (sel < 80) begin
        // carry on from the current chaining value without a restart
        send_tail(1'b1, 1'b0);
      end else if (sel < 90) begin
        send_item(rand_word(), 1'b1, 1'($urandom_range(1)));
        repeat ($urandom_range(13)) send_item(rand_word(), 1'b0, $urandom_range(5) == 0);
      end else begin
        repeat ($urandom_range(5, 1)) begin
          send_item(rand_word(), $urandom_range(3) == 0, 1'($urandom_range(1)));
        end
      end
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (150) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
